/* rtl/lwpf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lwpf_pkg: shared types and constants of the LCD window pixel framer
// Action and status codes, DCS command bytes and the front/back work entry.
// ----------------------------------------------------------------------------
package lwpf_pkg;

   // input actions
   localparam logic [1:0] ACT_FILL_START   = 2'd0;
   localparam logic [1:0] ACT_STREAM_START = 2'd1;
   localparam logic [1:0] ACT_FILL_PIXEL   = 2'd2;
   localparam logic [1:0] ACT_STREAM_PIXEL = 2'd3;

   // result status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_REJECT    = 2'd2;
   localparam logic [1:0] ST_NO_WINDOW = 2'd3;

   // DCS commands
   localparam logic [7:0] CMD_COLUMN = 8'h2a;
   localparam logic [7:0] CMD_ROW    = 8'h2b;
   localparam logic [7:0] CMD_WRITE  = 8'h2c;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PANEL_SIZE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PANEL_EN   = 2'd1;
   localparam int unsigned CSR_DATA_BITS = 11;
   localparam logic [10:0] PANEL_SIZE_RESET = 11'd240;

   // pixel counter
   localparam int unsigned CNT_BITS = 21;
   localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};

   // work queue
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_BITS = $clog2(QDEPTH);

   // work kinds
   localparam logic [1:0] KIND_HDR  = 2'd0;
   localparam logic [1:0] KIND_PIX  = 2'd1;
   localparam logic [1:0] KIND_LONE = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [15:0] x1;
      logic [15:0] x2;
      logic [15:0] y1;
      logic [15:0] y2;
      logic [15:0] pix;    // first byte to send in [15:8]
      logic        done;
   } work_type;

endpackage
`default_nettype wire

/* rtl/lwpf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lwpf_front: request classifier
// Holds the panel registers and window state, clips start rectangles and
// turns each accepted request into one work entry for the back end.
// ----------------------------------------------------------------------------
module lwpf_front #(
   parameter int unsigned COORD_BITS = 16,
   parameter int unsigned MAX_PANEL  = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [1:0]                           req_action,
   input  wire logic [15:0]                          req_left,
   input  wire logic [15:0]                          req_top,
   input  wire logic [15:0]                          req_right,
   input  wire logic [15:0]                          req_bottom,
   input  wire logic [15:0]                          req_pixel_value,
   input  wire logic                                 csr_valid,
   input  wire logic [lwpf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lwpf_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire logic                                 q_full,
   output      logic                                 push_valid,
   output      lwpf_pkg::work_type                   push_entry
);
   import lwpf_pkg::*;

   localparam int unsigned SIZE_BITS = $clog2(MAX_PANEL + 1);
   localparam int unsigned CMPW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
   localparam int unsigned PROD_BITS = (2 * SIZE_BITS > CNT_BITS) ? 2 * SIZE_BITS
                                                                  : CNT_BITS + 1;
   localparam logic [12:0] MAXP = 13'(MAX_PANEL);

   logic [10:0]          panel_size_ff;
   logic                 panel_en_ff;
   logic [CNT_BITS-1:0]  pixels_left_ff, pixels_left_in;
   logic                 fill_mode_ff, fill_mode_in;
   logic [15:0]          fill_colour_ff, fill_colour_in;
   logic                 mul_busy_ff, mul_busy_in;
   logic [SIZE_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;

   logic [SIZE_BITS-1:0] edge_s;
   logic [CMPW-1:0]      x1w, y1w, x2w, y2w, x2c, y2c, sw;
   logic [PROD_BITS-1:0] prod;
   logic                 accept, is_start, is_fill, off_panel, inverted;

   assign req_stall = q_full || mul_busy_ff;
   assign accept    = req_valid && !req_stall;
   assign is_start  = (req_action == ACT_FILL_START) || (req_action == ACT_STREAM_START);
   assign is_fill   = (req_action == ACT_FILL_START) || (req_action == ACT_FILL_PIXEL);

   // clamp panel edge into 1..MAX_PANEL
   always_comb begin
      if (panel_size_ff == 11'd0) begin
         edge_s = SIZE_BITS'(1);
      end else if (13'(panel_size_ff) > MAXP) begin
         edge_s = SIZE_BITS'(MAXP);
      end else begin
         edge_s = SIZE_BITS'(panel_size_ff);
      end
   end

   assign sw  = CMPW'(edge_s);
   assign x1w = CMPW'(req_left[COORD_BITS-1:0]);
   assign y1w = CMPW'(req_top[COORD_BITS-1:0]);
   assign x2w = CMPW'(req_right[COORD_BITS-1:0]);
   assign y2w = CMPW'(req_bottom[COORD_BITS-1:0]);
   assign x2c = (x2w >= sw) ? sw - CMPW'(1) : x2w;
   assign y2c = (y2w >= sw) ? sw - CMPW'(1) : y2w;
   assign off_panel = (x1w >= sw) || (y1w >= sw);
   assign inverted  = (x2c < x1w) || (y2c < y1w);

   assign prod = PROD_BITS'(dx_ff) * PROD_BITS'(dy_ff);

   always_comb begin
      pixels_left_in = pixels_left_ff;
      fill_mode_in   = fill_mode_ff;
      fill_colour_in = fill_colour_ff;
      mul_busy_in    = 1'b0;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      push_valid     = accept;
      push_entry     = '0;
      push_entry.kind   = KIND_LONE;
      push_entry.x1     = 16'(x1w);
      push_entry.x2     = 16'(x2c);
      push_entry.y1     = 16'(y1w);
      push_entry.y2     = 16'(y2c);

      // finish the window size in the cycle after its start
      if (mul_busy_ff) begin
         pixels_left_in = (prod > PROD_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                         : prod[CNT_BITS-1:0];
      end

      if (accept) begin
         if (is_start) begin
            pixels_left_in = '0;
            if (!is_fill && !panel_en_ff) begin
               push_entry.status = ST_REJECT;
            end else if (off_panel) begin
               push_entry.status = is_fill ? ST_EMPTY : ST_REJECT;
            end else if (inverted) begin
               push_entry.status = ST_EMPTY;
            end else begin
               push_entry.kind = KIND_HDR;
               fill_mode_in    = is_fill;
               if (is_fill) begin
                  fill_colour_in = req_pixel_value;
               end
               dx_in       = SIZE_BITS'(x2c - x1w + CMPW'(1));
               dy_in       = SIZE_BITS'(y2c - y1w + CMPW'(1));
               mul_busy_in = 1'b1;
            end
         end else if (pixels_left_ff == '0 || fill_mode_ff != is_fill) begin
            push_entry.status = ST_NO_WINDOW;
         end else begin
            push_entry.kind = KIND_PIX;
            push_entry.done = (pixels_left_ff == CNT_BITS'(1));
            push_entry.pix  = is_fill ? fill_colour_ff
                                      : {req_pixel_value[7:0], req_pixel_value[15:8]};
            pixels_left_in  = pixels_left_ff - CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_size_ff  <= PANEL_SIZE_RESET;
         panel_en_ff    <= 1'b0;
         pixels_left_ff <= '0;
         fill_mode_ff   <= 1'b0;
         fill_colour_ff <= '0;
         mul_busy_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_PANEL_SIZE) begin
            panel_size_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_PANEL_EN) begin
            panel_en_ff <= csr_data[0];
         end
         pixels_left_ff <= pixels_left_in;
         fill_mode_ff   <= fill_mode_in;
         fill_colour_ff <= fill_colour_in;
         mul_busy_ff    <= mul_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   // size multiply busy is never set back to back
   a_mul_single : assert property (@(posedge clock) disable iff (reset)
      mul_busy_ff |=> !mul_busy_ff)
      else $error("window size multiply held for two cycles");

endmodule
`default_nettype wire

/* rtl/lwpf_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lwpf_queue: work queue between classifier and byte sequencer
// Small register FIFO; head entry is presented directly from storage.
// ----------------------------------------------------------------------------
module lwpf_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire lwpf_pkg::work_type push_entry,
   output      logic               q_full,
   output      logic               head_valid,
   output      lwpf_pkg::work_type head_entry,
   input  wire logic               pop
);
   import lwpf_pkg::*;

   work_type              entries_ff [QDEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]    count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_full     = (count_ff == (QPTR_BITS+1)'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !q_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

/* rtl/lwpf_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lwpf_back: byte sequencer
// Walks the head work entry beat by beat into the registered result channel.
// ----------------------------------------------------------------------------
module lwpf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire lwpf_pkg::work_type head_entry,
   output      logic               pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [7:0]         rsp_data_byte,
   output      logic               rsp_is_data,
   output      logic               rsp_byte_valid,
   output      logic               rsp_last,
   output      logic [1:0]         rsp_status,
   output      logic               rsp_rect_done
);
   import lwpf_pkg::*;

   localparam logic [3:0] B_COL = 4'd0;
   localparam logic [3:0] B_X1H = 4'd1;
   localparam logic [3:0] B_X1L = 4'd2;
   localparam logic [3:0] B_X2H = 4'd3;
   localparam logic [3:0] B_X2L = 4'd4;
   localparam logic [3:0] B_ROW = 4'd5;
   localparam logic [3:0] B_Y1H = 4'd6;
   localparam logic [3:0] B_Y1L = 4'd7;
   localparam logic [3:0] B_Y2H = 4'd8;
   localparam logic [3:0] B_Y2L = 4'd9;
   localparam logic [3:0] B_WR  = 4'd10;
   localparam logic [3:0] B_PIX_FIRST = 4'd0;

   logic [3:0] beat_ff;
   logic       rsp_valid_ff;
   logic [7:0] data_ff, data_in;
   logic       dc_ff, dc_in, bv_ff, bv_in, last_ff, last_in, done_ff, done_in;
   logic [1:0] status_ff, status_in;
   logic       out_free, advance;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = head_valid && out_free;
   assign pop      = advance && last_in;

   always_comb begin
      data_in   = 8'h00;
      dc_in     = 1'b1;
      bv_in     = 1'b1;
      last_in   = 1'b0;
      status_in = ST_OK;
      done_in   = 1'b0;
      case (head_entry.kind)
         KIND_HDR: begin
            case (beat_ff)
               B_COL: begin
                  data_in = CMD_COLUMN;
                  dc_in   = 1'b0;
               end
               B_X1H:   data_in = head_entry.x1[15:8];
               B_X1L:   data_in = head_entry.x1[7:0];
               B_X2H:   data_in = head_entry.x2[15:8];
               B_X2L:   data_in = head_entry.x2[7:0];
               B_ROW: begin
                  data_in = CMD_ROW;
                  dc_in   = 1'b0;
               end
               B_Y1H:   data_in = head_entry.y1[15:8];
               B_Y1L:   data_in = head_entry.y1[7:0];
               B_Y2H:   data_in = head_entry.y2[15:8];
               B_Y2L:   data_in = head_entry.y2[7:0];
               default: begin
                  data_in = CMD_WRITE;
                  dc_in   = 1'b0;
                  last_in = 1'b1;
               end
            endcase
         end
         KIND_PIX: begin
            if (beat_ff == B_PIX_FIRST) begin
               data_in = head_entry.pix[15:8];
            end else begin
               data_in = head_entry.pix[7:0];
               last_in = 1'b1;
               done_in = head_entry.done;
            end
         end
         default: begin
            // lone status result, no byte on the wire
            dc_in     = 1'b0;
            bv_in     = 1'b0;
            last_in   = 1'b1;
            status_in = head_entry.status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= head_valid;
         end
         if (advance) begin
            beat_ff <= last_in ? '0 : beat_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff   <= data_in;
         dc_ff     <= dc_in;
         bv_ff     <= bv_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         done_ff   <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_is_data    = dc_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;
   assign rsp_rect_done  = done_ff;

   a_done_on_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> last_ff && bv_ff)
      else $error("rect_done on a beat that is not a final pixel byte");

   a_lone_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !bv_ff |-> last_ff && status_ff != ST_OK && data_ff == 8'h00)
      else $error("status-only beat malformed");

   a_beat_range : assert property (@(posedge clock) disable iff (reset)
      beat_ff <= B_WR)
      else $error("beat counter past header end");

endmodule
`default_nettype wire

/* rtl/lcd_window_pixel_framer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_window_pixel_framer_top: DCS window write framer for a 4-wire SPI panel
// Turns rectangle and pixel requests into command/parameter/pixel bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one beat per request (start fill, start stream, pixel).
//    A beat is taken when req_valid is high and req_stall is low.
//  - rsp_* channel: one beat per byte slot toward the SPI shifter; the
//    receiver holds rsp_stall high to keep the current beat.
//  - csr_* port: register writes, always ready; write only while idle.
//  - A request beat is stored in the work queue, then its first result beat is registered at the output.
//  - Throughput: a pixel request yields two beats, and the byte sequencer
//    sends one beat per cycle unless the receiver stalls.
//    A good start yields 11 beats; the classifier also stalls requests in the
//    cycle after it to multiply out the window size.
//  - A four-entry work queue separates classifier and sequencer, so requests
//    keep flowing while the receiver stalls until the queue fills.
//  - Reset: panel size 240, panel disabled, no pending window, queue empty.
// ----------------------------------------------------------------------------
module lcd_window_pixel_framer_top #(
   parameter int unsigned COORD_BITS = 16,
   parameter int unsigned MAX_PANEL  = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // requests
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [1:0]                           req_action,
   input  wire logic [15:0]                          req_left,
   input  wire logic [15:0]                          req_top,
   input  wire logic [15:0]                          req_right,
   input  wire logic [15:0]                          req_bottom,
   input  wire logic [15:0]                          req_pixel_value,
   // results
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [7:0]                           rsp_data_byte,
   output      logic                                 rsp_is_data,
   output      logic                                 rsp_byte_valid,
   output      logic                                 rsp_last,
   output      logic [1:0]                           rsp_status,
   output      logic                                 rsp_rect_done,
   // configuration
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [lwpf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lwpf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import lwpf_pkg::*;

   logic     q_full, push_valid, head_valid, pop;
   work_type push_entry, head_entry;

   // registers accept a write every cycle
   assign csr_ready = 1'b1;

   // front: classify requests, own the window state
   lwpf_front #(
      .COORD_BITS (COORD_BITS),
      .MAX_PANEL  (MAX_PANEL)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_left        (req_left),
      .req_top         (req_top),
      .req_right       (req_right),
      .req_bottom      (req_bottom),
      .req_pixel_value (req_pixel_value),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_full          (q_full),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   // hold work between the two sides
   lwpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // back: advance through the bytes of each entry
   lwpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_is_data    (rsp_is_data),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .rsp_rect_done  (rsp_rect_done)
   );

endmodule
`default_nettype wire

/* tb/lcd_window_pixel_framer_top_test.sv */
// ----------------------------------------------------------------------------
// lcd_window_pixel_framer_top_test: self-checking bench for the window framer
// Drives rectangle and pixel requests with random pacing on both channels,
// predicts every SPI byte beat (command, parameter, pixel, status) and
// compares each accepted beat, in order, against the predicted stream.
// ----------------------------------------------------------------------------
module lcd_window_pixel_framer_top_test;
   import lwpf_pkg::*;

   localparam int unsigned MAX_PANEL_PX     = 1024;    // DUT default MAX_PANEL
   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned ITEM_TARGET      = 270;
   localparam int unsigned MAX_GAP          = 14;
   localparam int unsigned LONG_HOLD_CYCLES = 200;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned REPORT_LIMIT     = 10;
   localparam int unsigned DIRECTED_ROWS    = 25;
   localparam int unsigned MAX_PIXEL_RUN    = 16;      // cap on the pixel run per window

   // panel setups used by the directed rows
   localparam logic [1:0] PH_RESET = 2'd0;   // reset values: 240, disabled
   localparam logic [1:0] PH_WIDE  = 2'd1;   // size above the maximum, enabled
   localparam logic [1:0] PH_TINY  = 2'd2;   // size zero (one pixel), enabled

   // one beat on the result channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_data;
      logic       byte_valid;
      logic       last;
      logic [1:0] status;
      logic       rect_done;
   } spi_beat_type;

   // one request; typed rows carry a lone-status beat written in by hand
   typedef struct packed {
      logic [1:0]  act;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [15:0] pix;
      logic [1:0]  phase;
      logic        typed;
      logic [1:0]  st;
   } request_row_type;

   // outcome of clipping a start against the panel
   typedef struct {
      logic [1:0]          status;
      logic [15:0]         x1;
      logic [15:0]         x2;
      logic [15:0]         y1;
      logic [15:0]         y2;
      logic [CNT_BITS-1:0] area;
   } window_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_FILL_START;
   logic [15:0] req_left = '0;
   logic [15:0] req_top = '0;
   logic [15:0] req_right = '0;
   logic [15:0] req_bottom = '0;
   logic [15:0] req_pixel_value = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_is_data;
   logic        rsp_byte_valid;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        rsp_rect_done;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_PANEL_SIZE;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // bench-side sideband that travels with each request beat
   logic        req_typed = 1'b0;
   logic [1:0]  req_typed_st = ST_OK;

   // predictor state and configuration shadow
   logic [10:0]         panel_size_q;
   logic                panel_en_q;
   logic [CNT_BITS-1:0] pixels_due;
   logic                fill_pending;
   logic [15:0]         fill_rgb;

   spi_beat_type spi_bytes_due[$];
   int unsigned  mismatch_count = 0;
   int unsigned  items_offered = 0;
   int unsigned  cycle_count = 0;

   // pacing controls shared by the sender, receiver and main sequence
   bit          req_no_idle = 1'b0;
   bit          rsp_no_idle = 1'b0;
   bit          long_hold_req = 1'b0;

   always #10 clock = ~clock;

   lcd_window_pixel_framer_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_left        (req_left),
      .req_top         (req_top),
      .req_right       (req_right),
      .req_bottom      (req_bottom),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_rect_done   (rsp_rect_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // --------------------------------------------------------------------------
   // Directed stimulus. Rows with typed set expect one status-only beat with
   // the given status; all others are checked against the predictor.
   // --------------------------------------------------------------------------
   request_row_type directed_rows [DIRECTED_ROWS] = '{
      // no window yet: both pixel kinds bounce
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
        PH_RESET, 1'b1, ST_NO_WINDOW},
      '{ACT_STREAM_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        PH_RESET, 1'b1, ST_NO_WINDOW},
      // stream start on a disabled panel
      '{ACT_STREAM_START, 16'h0000, 16'h0000, 16'h0009, 16'h0009, 16'h0000,
        PH_RESET, 1'b1, ST_REJECT},
      // fill starts with origin off the panel, then an inverted rectangle
      '{ACT_FILL_START,   16'hffff, 16'h0000, 16'hffff, 16'h0005, 16'h1234,
        PH_RESET, 1'b1, ST_EMPTY},
      '{ACT_FILL_START,   16'h0000, 16'h00f0, 16'h0005, 16'hffff, 16'h1234,
        PH_RESET, 1'b1, ST_EMPTY},
      '{ACT_FILL_START,   16'h0005, 16'h0005, 16'h0004, 16'h0009, 16'h1234,
        PH_RESET, 1'b1, ST_EMPTY},
      // full-screen fill clipped to 240, one pixel, then a wrong-kind pixel
      '{ACT_FILL_START,   16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff,
        PH_RESET, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        PH_RESET, 1'b0, ST_OK},
      '{ACT_STREAM_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5a5a,
        PH_RESET, 1'b1, ST_NO_WINDOW},
      // new start abandons the big window: 2x2 in the far corner, run it out
      '{ACT_FILL_START,   16'h00ee, 16'h00ee, 16'h00ef, 16'h00ef, 16'ha5c3,
        PH_RESET, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
        PH_RESET, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
        PH_RESET, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
        PH_RESET, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff,
        PH_RESET, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        PH_RESET, 1'b1, ST_NO_WINDOW},
      // widest panel: last column and row, clipped right and bottom
      '{ACT_STREAM_START, 16'h03ff, 16'h03ff, 16'hffff, 16'hffff, 16'h0000,
        PH_WIDE, 1'b0, ST_OK},
      '{ACT_STREAM_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8001,
        PH_WIDE, 1'b0, ST_OK},
      '{ACT_STREAM_START, 16'h0000, 16'hffff, 16'h0003, 16'h0003, 16'h0000,
        PH_WIDE, 1'b1, ST_REJECT},
      // stream window, wrong-kind pixel, then abandoned by an empty start
      '{ACT_STREAM_START, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
        PH_WIDE, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        PH_WIDE, 1'b1, ST_NO_WINDOW},
      '{ACT_FILL_START,   16'h0005, 16'h0005, 16'h0004, 16'h0004, 16'h0000,
        PH_WIDE, 1'b1, ST_EMPTY},
      '{ACT_STREAM_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hbeef,
        PH_WIDE, 1'b1, ST_NO_WINDOW},
      // size zero behaves as a single-pixel panel
      '{ACT_FILL_START,   16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h1234,
        PH_TINY, 1'b0, ST_OK},
      '{ACT_FILL_PIXEL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        PH_TINY, 1'b0, ST_OK},
      '{ACT_STREAM_START, 16'h0001, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
        PH_TINY, 1'b1, ST_REJECT}
   };

   // --------------------------------------------------------------------------
   // Predictor
   // --------------------------------------------------------------------------

   // effective panel edge: zero acts as one, clamp to the maximum
   function automatic int unsigned panel_edge();
      int unsigned px;
      px = 32'(panel_size_q);
      if (px == 0) px = 1;
      if (px > MAX_PANEL_PX) px = MAX_PANEL_PX;
      return px;
   endfunction

   // coordinates are 16 bits wide already, so the coordinate mask is a no-op
   function automatic window_type clip_window(input logic [1:0] act,
                                              input logic [15:0] l, t, r, b);
      window_type      w;
      int unsigned     px;
      longint unsigned area;
      px = panel_edge();
      w.status = ST_OK;
      w.x1 = l;
      w.y1 = t;
      w.x2 = r;
      w.y2 = b;
      w.area = '0;
      if (act == ACT_STREAM_START && !panel_en_q) begin
         w.status = ST_REJECT;
      end else if (32'(l) >= px || 32'(t) >= px) begin
         w.status = (act == ACT_FILL_START) ? ST_EMPTY : ST_REJECT;
      end else begin
         if (32'(r) >= px) w.x2 = 16'(px - 1);
         if (32'(b) >= px) w.y2 = 16'(px - 1);
         if (w.x2 < w.x1 || w.y2 < w.y1) begin
            w.status = ST_EMPTY;
         end else begin
            area = (64'(w.x2) - 64'(w.x1) + 64'd1) * (64'(w.y2) - 64'(w.y1) + 64'd1);
            w.area = (area > 64'(COUNT_MAX)) ? COUNT_MAX : CNT_BITS'(area);
         end
      end
      return w;
   endfunction

   function automatic void due_beat(input logic [7:0] data_byte, input logic dc,
                                    input logic bv, input logic lst,
                                    input logic [1:0] st, input logic done);
      spi_beat_type b;
      b = '{data_byte, dc, bv, lst, st, done};
      spi_bytes_due.push_back(b);
   endfunction

   // work out the beats one accepted request produces and advance the state
   function automatic void frame_request(input logic [1:0] act,
                                         input logic [15:0] l, t, r, b, pix);
      window_type w;
      logic       is_fill;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      case (act)
         ACT_FILL_START, ACT_STREAM_START: begin
            // any start drops the pending window, even a failing one
            pixels_due = '0;
            w = clip_window(act, l, t, r, b);
            if (w.status != ST_OK) begin
               due_beat(8'h00, 1'b0, 1'b0, 1'b1, w.status, 1'b0);
            end else begin
               pixels_due = w.area;
               fill_pending = (act == ACT_FILL_START);
               if (fill_pending) fill_rgb = pix;
               due_beat(CMD_COLUMN,    1'b0, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.x1[15:8],    1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.x1[7:0],     1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.x2[15:8],    1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.x2[7:0],     1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(CMD_ROW,       1'b0, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.y1[15:8],    1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.y1[7:0],     1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.y2[15:8],    1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(w.y2[7:0],     1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(CMD_WRITE,     1'b0, 1'b1, 1'b1, ST_OK, 1'b0);
            end
         end
         default: begin
            is_fill = (act == ACT_FILL_PIXEL);
            if (pixels_due == '0 || fill_pending != is_fill) begin
               due_beat(8'h00, 1'b0, 1'b0, 1'b1, ST_NO_WINDOW, 1'b0);
            end else begin
               // fill sends the stored colour high byte first, stream low first
               if (is_fill) begin
                  first_byte  = fill_rgb[15:8];
                  second_byte = fill_rgb[7:0];
               end else begin
                  first_byte  = pix[7:0];
                  second_byte = pix[15:8];
               end
               pixels_due = pixels_due - CNT_BITS'(1);
               due_beat(first_byte,  1'b1, 1'b1, 1'b0, ST_OK, 1'b0);
               due_beat(second_byte, 1'b1, 1'b1, 1'b1, ST_OK, pixels_due == '0);
            end
         end
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Checking: compare accepted result beats first, then predict from any
   // request beat taken at the same edge.
   // --------------------------------------------------------------------------
   function automatic void note_mismatch(input string what, input spi_beat_type want,
                                         input spi_beat_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch %0d (%s) at cycle %0d:", mismatch_count, what, cycle_count,
                  " expected byte=%02h dc=%0b bv=%0b last=%0b st=%0d done=%0b,",
                  want.data_byte, want.is_data, want.byte_valid, want.last,
                  want.status, want.rect_done,
                  " got byte=%02h dc=%0b bv=%0b last=%0b st=%0d done=%0b",
                  got.data_byte, got.is_data, got.byte_valid, got.last,
                  got.status, got.rect_done);
   endfunction

   always @(posedge clock) begin : beat_monitor
      spi_beat_type got;
      spi_beat_type want;
      int unsigned  queued;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_data_byte, rsp_is_data, rsp_byte_valid, rsp_last,
                    rsp_status, rsp_rect_done};
            if (spi_bytes_due.size() == 0) begin
               note_mismatch("no beat expected", '0, got);
            end else begin
               want = spi_bytes_due.pop_front();
               if (got.data_byte !== want.data_byte || got.is_data !== want.is_data ||
                   got.byte_valid !== want.byte_valid || got.last !== want.last ||
                   got.status !== want.status || got.rect_done !== want.rect_done)
                  note_mismatch("field differs", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            queued = spi_bytes_due.size();
            frame_request(req_action, req_left, req_top, req_right, req_bottom,
                          req_pixel_value);
            // typed rows: keep the state update, replace the predicted beats
            if (req_typed) begin
               while (spi_bytes_due.size() > queued) void'(spi_bytes_due.pop_back());
               due_beat(8'h00, 1'b0, 1'b0, 1'b1, req_typed_st, 1'b0);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Channel drivers
   // --------------------------------------------------------------------------

   // Offer one request beat after a random gap; return at the edge that takes
   // it. Valid stays high into the next call when that one draws no gap.
   task automatic offer_request(input request_row_type row);
      int unsigned gap;
      gap = req_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= row.act;
      req_left        <= row.left;
      req_top         <= row.top;
      req_right       <= row.right;
      req_bottom      <= row.bottom;
      req_pixel_value <= row.pix;
      req_typed       <= row.typed;
      req_typed_st    <= row.st;
      items_offered++;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   function automatic request_row_type make_row(input logic [1:0] act,
                                                input logic [15:0] l, t, r, b, p);
      return '{act, l, t, r, b, p, PH_RESET, 1'b0, ST_OK};
   endfunction

   // one register write; valid is left high for a back-to-back write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PANEL_SIZE)
         panel_size_q = data;
      else if (idx == CSR_PANEL_EN)
         panel_en_q = data[0];
   endtask

   task automatic program_panel(input logic [10:0] size_word,
                                input logic [10:0] en_word);
      write_reg(CSR_PANEL_SIZE, size_word);
      write_reg(CSR_PANEL_EN, en_word);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for every predicted beat, then let the pipe go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (spi_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: draw a stall length per beat, then take the next beat.
   // A long hold-off, when requested, replaces one draw so the work queue
   // fills and the request side backs up.
   initial begin : rsp_pacer
      int unsigned hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            hold = rsp_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // hard stop on a hung handshake
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin : main_seq
      logic [1:0]  cur_phase;
      logic [1:0]  act;
      logic [10:0] size_word;
      logic [15:0] l, t, r, b;
      logic        fill;
      window_type  w;
      int unsigned px;
      int unsigned pick;
      int unsigned pixels;
      int unsigned scene;
      int unsigned scene_end;

      // shadow the reset state of the block
      panel_size_q = PANEL_SIZE_RESET;
      panel_en_q   = 1'b0;
      pixels_due   = '0;
      fill_pending = 1'b0;
      fill_rgb     = '0;

      // hold reset, then release it once
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows; switch the panel setup only with the block drained
      cur_phase = PH_RESET;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].phase != cur_phase) begin
            settle();
            case (directed_rows[i].phase)
               PH_WIDE: program_panel(11'h7ff, 11'h001);
               PH_TINY: program_panel(11'h000, 11'h7ff);
               default: program_panel(PANEL_SIZE_RESET, 11'h000);
            endcase
            cur_phase = directed_rows[i].phase;
         end
         offer_request(directed_rows[i]);
      end

      // random scenes: each drains, picks a panel setup, then runs mostly
      // well-formed windows with their pixels plus noise and broken sequences
      scene = 0;
      while (items_offered < ITEM_TARGET) begin
         settle();
         case (scene % 8)
            0: size_word = 11'd16;
            1: size_word = 11'd1;
            2: size_word = 11'd0;
            3: size_word = 11'h7ff;
            4: size_word = 11'd1024;
            5: size_word = 11'd240;
            6: size_word = 11'($urandom_range(1, 2047));
            default: size_word = 11'd2;
         endcase
         // upper bits of the enable word are don't-care; scene 5 disables
         program_panel(size_word, {10'($urandom), scene % 8 != 5});

         // pacing: scene 0 floods the receiver's long hold-off, every fourth
         // scene runs without any idling on either side
         req_no_idle = (scene == 0) || (scene % 4 == 2);
         rsp_no_idle = (scene % 4 == 2);
         if (scene == 0) long_hold_req = 1'b1;

         px = panel_edge();
         scene_end = items_offered + $urandom_range(20, 40);
         while (items_offered < scene_end && items_offered < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               // well-formed window: small rectangle near a random origin
               fill = 1'($urandom_range(0, 1));
               act = fill ? ACT_FILL_START : ACT_STREAM_START;
               l = 16'($urandom_range(0, px - 1));
               t = 16'($urandom_range(0, px - 1));
               r = ($urandom_range(0, 7) == 0) ? 16'hffff : l + 16'($urandom_range(0, 3));
               b = ($urandom_range(0, 7) == 0) ? 16'hffff : t + 16'($urandom_range(0, 3));
               offer_request(make_row(act, l, t, r, b, 16'($urandom)));
               w = clip_window(act, l, t, r, b);
               pixels = 32'(w.area);
               // a window clipped to the panel edge can be huge; cut it short
               if (pixels > MAX_PIXEL_RUN) pixels = MAX_PIXEL_RUN;
               // now and then abandon the window early or overrun it
               if ($urandom_range(0, 6) == 0 && pixels > 1)
                  pixels = $urandom_range(1, pixels - 1);
               else if ($urandom_range(0, 9) == 0)
                  pixels++;
               repeat (pixels)
                  offer_request(make_row(fill ? ACT_FILL_PIXEL : ACT_STREAM_PIXEL,
                                         16'($urandom), 16'($urandom), 16'($urandom),
                                         16'($urandom), 16'($urandom)));
            end else if (pick < 90) begin
               // noise: every field fully random
               offer_request(make_row(2'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom)));
            end else if ($urandom_range(0, 1) == 0) begin
               // stray pixel of either kind
               act = $urandom_range(0, 1) ? ACT_FILL_PIXEL : ACT_STREAM_PIXEL;
               offer_request(make_row(act, '0, '0, '0, '0, 16'($urandom)));
            end else begin
               // start with its origin just past the panel edge
               act = $urandom_range(0, 1) ? ACT_FILL_START : ACT_STREAM_START;
               if ($urandom_range(0, 1) == 0)
                  offer_request(make_row(act, 16'(px), '0, 16'(px), 16'd3, 16'($urandom)));
               else
                  offer_request(make_row(act, '0, 16'(px), 16'd3, 16'(px), 16'($urandom)));
            end
         end
         scene++;
      end

      // drain and let any stray beat show up before judging
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;
      settle();
      if (mismatch_count == 0 && spi_bytes_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
